### rtl/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// Shared types and codes for the double-ended priority queue unit.
// ----------------------------------------------------------------------------
package dep_pkg;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

  // Item actions
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REM_MIN = 2'd1;
  localparam logic [1:0] ACT_REM_MAX = 2'd2;

  // Result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Datapath register operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_ACCEPT  = 4'd1;
  localparam op_t OP_INS0    = 4'd2;
  localparam op_t OP_INS1    = 4'd3;
  localparam op_t OP_UP      = 4'd4;
  localparam op_t OP_CHL     = 4'd5;
  localparam op_t OP_CHR     = 4'd6;
  localparam op_t OP_DN      = 4'd7;
  localparam op_t OP_REMH    = 4'd8;
  localparam op_t OP_ROOT    = 4'd9;
  localparam op_t OP_LOAD    = 4'd10;
  localparam op_t OP_SWAPH   = 4'd11;
  localparam op_t OP_CNT_INC = 4'd12;
  localparam op_t OP_CNT_DEC = 4'd13;

  // Read address select
  typedef logic [2:0] ra_t;
  localparam ra_t RA_NONE   = 3'd0;
  localparam ra_t RA_PARENT = 3'd1;
  localparam ra_t RA_LEFT   = 3'd2;
  localparam ra_t RA_RIGHT  = 3'd3;
  localparam ra_t RA_ROOT   = 3'd4;
  localparam ra_t RA_LAST   = 3'd5;

  // Write source select
  typedef logic [1:0] wr_t;
  localparam wr_t WR_NONE  = 2'd0;
  localparam wr_t WR_MOVE  = 2'd1;
  localparam wr_t WR_CHILD = 2'd2;
  localparam wr_t WR_PLACE = 2'd3;

  typedef struct packed {
    op_t        op;
    ra_t        rd;
    wr_t        wr;
    logic       set_stat;
    logic [1:0] stat;
    logic       emit;
  } dep_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       i_zero;
    logic       up_wins;
    logic       l_lt_m;
    logic       r_lt_m;
    logic       r_better;
    logic       v_wins_c;
    logic       at_last;
  } dep_sts_t;

endpackage

### rtl/dep_if.sv
// ----------------------------------------------------------------------------
// dep_if
// Valid/ready channel interfaces of the double-ended priority queue unit.
// ----------------------------------------------------------------------------
interface dep_in_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [DATA_WIDTH-1:0] value;
  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dep_out_if #(parameter int DATA_WIDTH = 32, parameter int COUNT_W = 11);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] removed_value;
  logic [1:0]            status;
  logic [COUNT_W-1:0]    count_after;
  modport source (output valid, output removed_value, output status, output count_after,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input count_after,
                  output ready);
endinterface

interface dep_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] capacity_limit;
  modport source (output valid, output capacity_limit, input ready);
  modport sink   (input valid, input capacity_limit, output ready);
endinterface

### rtl/dep_ctrl.sv
// ----------------------------------------------------------------------------
// dep_ctrl
// Sequencer: decodes an item and steps the datapath through the sifts.
// ----------------------------------------------------------------------------
module dep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dep_pkg::dep_sts_t sts,
  output dep_pkg::dep_cmd_t cmd
);
  import dep_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_REM_ROOT = 4'd2;
  localparam logic [3:0] S_RM_BEGIN = 4'd3;
  localparam logic [3:0] S_RM_LOAD  = 4'd4;
  localparam logic [3:0] S_UP       = 4'd5;
  localparam logic [3:0] S_UP_CMP   = 4'd6;
  localparam logic [3:0] S_DOWN     = 4'd7;
  localparam logic [3:0] S_DN_L     = 4'd8;
  localparam logic [3:0] S_DN_R     = 4'd9;
  localparam logic [3:0] S_DN_CMP   = 4'd10;
  localparam logic [3:0] S_PLACE    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic [1:0] PH_INS0 = 2'd0;
  localparam logic [1:0] PH_INS1 = 2'd1;
  localparam logic [1:0] PH_REM0 = 2'd2;
  localparam logic [1:0] PH_REM1 = 2'd3;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       moved_r, moved_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       stop_up;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // an insert never sifts down; a removal sifts down only if it did not climb
  assign stop_up   = moved_r || (phase_r == PH_INS0) || (phase_r == PH_INS1);

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.rd       = RA_NONE;
    cmd.wr       = WR_NONE;
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    moved_nxt    = moved_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_stat = 1'b1;
        cmd.stat     = ST_OK;
        priority if (sts.action == ACT_INSERT) begin
          if (sts.full) begin
            cmd.stat  = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_INS0;
            phase_nxt = PH_INS0;
            moved_nxt = 1'b0;
            state_nxt = S_UP;
          end
        end else if (sts.action == ACT_REM_MIN || sts.action == ACT_REM_MAX) begin
          if (sts.empty) begin
            cmd.stat  = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_REMH;
            cmd.rd    = RA_ROOT;
            phase_nxt = PH_REM0;
            state_nxt = S_REM_ROOT;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_REM_ROOT: begin
        cmd.op    = OP_ROOT;
        state_nxt = S_RM_BEGIN;
      end
      S_RM_BEGIN: begin
        if (sts.at_last) begin
          // deleting the last entry needs no repair
          if (phase_r == PH_REM0) begin
            cmd.op    = OP_SWAPH;
            phase_nxt = PH_REM1;
          end else begin
            cmd.op    = OP_CNT_DEC;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.rd    = RA_LAST;
          state_nxt = S_RM_LOAD;
        end
      end
      S_RM_LOAD: begin
        cmd.op    = OP_LOAD;
        moved_nxt = 1'b0;
        state_nxt = S_UP;
      end
      S_UP: begin
        if (sts.i_zero) begin
          state_nxt = stop_up ? S_PLACE : S_DOWN;
        end else begin
          cmd.rd    = RA_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_wins) begin
          cmd.wr    = WR_MOVE;
          cmd.op    = OP_UP;
          moved_nxt = 1'b1;
          state_nxt = S_UP;
        end else begin
          state_nxt = stop_up ? S_PLACE : S_DOWN;
        end
      end
      S_DOWN: begin
        if (sts.l_lt_m) begin
          cmd.rd    = RA_LEFT;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_L: begin
        cmd.op = OP_CHL;
        if (sts.r_lt_m) begin
          cmd.rd    = RA_RIGHT;
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.op    = OP_CHR;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.v_wins_c) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.wr    = WR_CHILD;
          cmd.op    = OP_DN;
          state_nxt = S_DOWN;
        end
      end
      S_PLACE: begin
        cmd.wr = WR_PLACE;
        unique case (phase_r)
          PH_INS0: begin
            cmd.op    = OP_INS1;
            phase_nxt = PH_INS1;
            moved_nxt = 1'b0;
            state_nxt = S_UP;
          end
          PH_INS1: begin
            cmd.op    = OP_CNT_INC;
            state_nxt = S_DONE;
          end
          PH_REM0: begin
            cmd.op    = OP_SWAPH;
            phase_nxt = PH_REM1;
            state_nxt = S_RM_BEGIN;
          end
          default: begin
            cmd.op    = OP_CNT_DEC;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_INS0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/dep_dpath.sv
// ----------------------------------------------------------------------------
// dep_dpath
// Heap memories, working registers, comparators and result register.
// ----------------------------------------------------------------------------
module dep_dpath #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int COUNT_W    = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dep_pkg::dep_cmd_t         cmd,
  output dep_pkg::dep_sts_t         sts,
  input  logic [1:0]                in_action,
  input  logic [DATA_WIDTH-1:0]     in_value,
  input  logic                      cfg_we,
  input  logic [dep_pkg::CFG_W-1:0] cfg_data,
  output logic [DATA_WIDTH-1:0]     out_removed,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_count
);
  import dep_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int XW = ((COUNT_W > CFG_W) ? COUNT_W : CFG_W) + 1;

  logic [DATA_WIDTH-1:0] val0_mem [DEPTH];
  logic [DATA_WIDTH-1:0] val1_mem [DEPTH];
  logic [PW-1:0]         tw0_mem  [DEPTH];
  logic [PW-1:0]         tw1_mem  [DEPTH];

  logic [DATA_WIDTH-1:0] rdv0_r, rdv1_r;
  logic [PW-1:0]         rdt0_r, rdt1_r;

  logic [1:0]            action_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [COUNT_W-1:0]    n_r;
  logic [CFG_W-1:0]      cfg_r;
  logic                  h_r;
  logic [PW-1:0]         i_r;
  logic [DATA_WIDTH-1:0] v_r;
  logic [PW-1:0]         t_r;
  logic [DATA_WIDTH-1:0] cv_r;
  logic [PW-1:0]         ct_r;
  logic [PW-1:0]         ci_r;
  logic [DATA_WIDTH-1:0] removed_r;
  logic [PW-1:0]         tsave_r;
  logic [1:0]            stat_r;
  logic [DATA_WIDTH-1:0] out_removed_r;
  logic [1:0]            out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [PW-1:0]         last;
  logic [PW-1:0]         par;
  logic [PW+1:0]         lw, rw, mx;
  logic [DATA_WIDTH-1:0] rv;
  logic [PW-1:0]         rt;
  logic [PW-1:0]         ra;
  logic                  we;
  logic [DATA_WIDTH-1:0] wv;
  logic [PW-1:0]         wt;

  function automatic logic wins(input logic hh, input logic [DATA_WIDTH-1:0] a,
                                input logic [DATA_WIDTH-1:0] b);
    return hh ? (a >= b) : (a <= b);
  endfunction

  assign last = PW'(n_r - COUNT_W'(1));
  assign par  = (i_r - PW'(1)) >> 1;
  assign lw   = {1'b0, i_r, 1'b1};
  assign rw   = lw + (PW+2)'(1);
  assign mx   = {2'b00, last};
  assign rv   = h_r ? rdv1_r : rdv0_r;
  assign rt   = h_r ? rdt1_r : rdt0_r;

  always_comb begin
    sts          = '0;
    sts.action   = action_r;
    sts.full     = (XW'(n_r) >= XW'(cfg_r)) || (n_r >= COUNT_W'(DEPTH));
    sts.empty    = (n_r == '0);
    sts.i_zero   = (i_r == '0);
    sts.up_wins  = h_r ? (v_r > rv) : (v_r < rv);
    sts.l_lt_m   = (lw < mx);
    sts.r_lt_m   = (rw < mx);
    sts.r_better = !wins(h_r, cv_r, rv);
    sts.v_wins_c = wins(h_r, v_r, cv_r);
    sts.at_last  = (i_r == last);
  end

  always_comb begin
    unique case (cmd.rd)
      RA_PARENT: ra = par;
      RA_LEFT:   ra = lw[PW-1:0];
      RA_RIGHT:  ra = rw[PW-1:0];
      RA_LAST:   ra = last;
      default:   ra = '0;
    endcase
  end

  always_comb begin
    we = 1'b1;
    unique case (cmd.wr)
      WR_MOVE: begin
        wv = rv;
        wt = rt;
      end
      WR_CHILD: begin
        wv = cv_r;
        wt = ct_r;
      end
      WR_PLACE: begin
        wv = v_r;
        wt = t_r;
      end
      default: begin
        we = 1'b0;
        wv = v_r;
        wt = t_r;
      end
    endcase
  end

  // Entry lands at i_r in the active heap; its twin's back pointer follows.
  always_ff @(posedge clk) begin
    if (we) begin
      if (h_r) begin
        val1_mem[i_r] <= wv;
        tw1_mem[i_r]  <= wt;
        tw0_mem[wt]   <= i_r;
      end else begin
        val0_mem[i_r] <= wv;
        tw0_mem[i_r]  <= wt;
        tw1_mem[wt]   <= i_r;
      end
    end
    rdv0_r <= val0_mem[ra];
    rdv1_r <= val1_mem[ra];
    rdt0_r <= tw0_mem[ra];
    rdt1_r <= tw1_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      cfg_r <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.op == OP_CNT_INC) begin
        n_r <= n_r + COUNT_W'(1);
      end else if (cmd.op == OP_CNT_DEC) begin
        n_r <= n_r - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        action_r  <= in_action;
        value_r   <= in_value;
        removed_r <= '0;
      end
      OP_INS0: begin
        h_r <= 1'b0;
        i_r <= n_r[PW-1:0];
        v_r <= value_r;
        t_r <= n_r[PW-1:0];
      end
      OP_INS1: begin
        h_r <= 1'b1;
        i_r <= n_r[PW-1:0];
        v_r <= value_r;
        t_r <= i_r;
      end
      OP_UP:   i_r <= par;
      OP_CHL: begin
        cv_r <= rv;
        ct_r <= rt;
        ci_r <= lw[PW-1:0];
      end
      OP_CHR: begin
        if (sts.r_better) begin
          cv_r <= rv;
          ct_r <= rt;
          ci_r <= rw[PW-1:0];
        end
      end
      OP_DN:   i_r <= ci_r;
      OP_REMH: h_r <= (action_r == ACT_REM_MAX);
      OP_ROOT: begin
        removed_r <= rv;
        tsave_r   <= rt;
        i_r       <= '0;
      end
      OP_LOAD: begin
        v_r <= rv;
        t_r <= rt;
      end
      OP_SWAPH: begin
        h_r <= ~h_r;
        i_r <= tsave_r;
      end
      default: begin
      end
    endcase
    if (cmd.set_stat) begin
      stat_r <= cmd.stat;
    end
    if (cmd.emit) begin
      out_removed_r <= removed_r;
      out_status_r  <= stat_r;
      out_count_r   <= n_r;
    end
  end

  assign out_removed = out_removed_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;

endmodule

### rtl/double_ended_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Bounded min/max queue built from two twinned binary heaps in memory.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | transfer
//  in_if    | in  | action, value                         | valid & ready
//  out_if   | out | removed_value, status, count_after    | valid & ready
//  cfg_if   | in  | capacity_limit                        | valid & ready (always ready)
//
//  One item at a time. An insert sifts up in each heap in turn; a removal takes
//  the root of one heap and the twin entry of the other, moving the last entry
//  into each hole and sifting it down or up.
//  The single read port of each heap memory sets the pace: one entry read per
//  step, data registered.
//  A finished result waits in the output register while the next item runs.
//  Reset (rst_n, synchronous) empties the queue and sets capacity to 1024.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  dep_in_if.sink    in_if,
  dep_out_if.source out_if,
  dep_cfg_if.sink   cfg_if
);
  import dep_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);

  dep_cmd_t cmd;
  dep_sts_t sts;

  assign cfg_if.ready = 1'b1;

  dep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dep_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .COUNT_W    (COUNT_W)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (in_if.action),
    .in_value    (in_if.value),
    .cfg_we      (cfg_if.valid),
    .cfg_data    (cfg_if.capacity_limit),
    .out_removed (out_if.removed_value),
    .out_status  (out_if.status),
    .out_count   (out_if.count_after)
  );

endmodule

### rtl/dep_checker.sv
// ----------------------------------------------------------------------------
// dep_checker
// Port-level checks for the double-ended priority queue unit.
// ----------------------------------------------------------------------------
module dep_checker #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int COUNT_W    = 11
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] removed_value,
  input logic [1:0]            status,
  input logic [COUNT_W-1:0]    count_after
);
  import dep_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(removed_value) && $stable(status)
      && $stable(count_after))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_after <= COUNT_W'(DEPTH))
    else $error("count beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL || status == ST_EMPTY) |-> removed_value == '0)
    else $error("error result carries a value");

endmodule

bind double_ended_priority_queue_unit dep_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .COUNT_W    (COUNT_W)
) u_dep_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .removed_value (out_if.removed_value),
  .status        (out_if.status),
  .count_after   (out_if.count_after)
);
